// ----- rtl/auwa_pkg.sv -----
package auwa_pkg;

    localparam int DEGREE_W     = 9;
    localparam int FILTERED_W   = 10;
    localparam int DATA_W       = 32;
    localparam int TURN_DEGREES = 360;
    localparam int SCALE        = 10;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_HIGH = 1'b1;

    localparam logic [DEGREE_W-1:0] WRAP_LOW_RESET  = 9'd50;
    localparam logic [DEGREE_W-1:0] WRAP_HIGH_RESET = 9'd300;

    typedef struct packed {
        logic [DEGREE_W-1:0] wrap_low;
        logic [DEGREE_W-1:0] wrap_high;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- rtl/auwa_front.sv -----
module auwa_front #(
    parameter int WINDOW_LENGTH = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  auwa_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [auwa_pkg::DEGREE_W-1:0] i_raw_degree,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output logic [auwa_pkg::DATA_W-1:0]   o_numerator
);
    import auwa_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_LENGTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);
    localparam logic [DATA_W-1:0] SCALED_N = DATA_W'(WINDOW_LENGTH * SCALE);
    localparam logic [DATA_W-1:0] TURN     = DATA_W'(TURN_DEGREES);

    logic                     r_seen;
    logic [DEGREE_W-1:0]      r_prev_raw;
    logic [DATA_W-1:0]        r_prev_u;
    logic [DATA_W-1:0]        r_num;
    logic [DATA_W-1:0]        r_total;
    logic [IDX_W-1:0]         r_idx;
    logic [WINDOW_LENGTH-1:0] r_vld;
    logic [DATA_W-1:0]        r_rd;
    logic [DATA_W-1:0]        r_ring [WINDOW_LENGTH];

    logic                     w_accept;
    logic [DATA_W-1:0]        w_raw;
    logic [DATA_W-1:0]        w_u;
    logic [DATA_W-1:0]        w_entry;
    logic [DATA_W-1:0]        w_weighted;
    logic [DATA_W-1:0]        w_old;
    logic [DATA_W-1:0]        n_num;
    logic [DATA_W-1:0]        n_total;
    logic [IDX_W-1:0]         n_idx;

    assign w_accept   = i_in_valid && !i_queue_full;
    assign o_in_stall = i_queue_full;
    assign w_raw      = DATA_W'(i_raw_degree);

    always_comb begin
        if (!r_seen) begin
            w_u = w_raw + TURN;
        end else begin
            w_u = r_prev_u + w_raw - DATA_W'(r_prev_raw);
            if (i_raw_degree < i_cfg.wrap_low && r_prev_raw > i_cfg.wrap_high) begin
                w_u = w_u + TURN;
            end else if (i_raw_degree > i_cfg.wrap_high && r_prev_raw < i_cfg.wrap_low) begin
                w_u = w_u - TURN;
            end
        end
    end

    assign w_entry    = (w_u << 3) + (w_u << 1);
    assign w_weighted = w_u * SCALED_N;
    assign w_old      = r_vld[r_idx] ? r_rd : '0;
    assign n_num      = r_num + w_weighted - r_total;
    assign n_total    = r_total - w_old + w_entry;

    always_comb begin
        n_idx = r_idx;
        if (w_accept) begin
            n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_prev_raw <= '0;
            r_prev_u   <= '0;
            r_num      <= '0;
            r_total    <= '0;
            r_idx      <= '0;
            r_vld      <= '0;
        end else if (w_accept) begin
            r_seen       <= 1'b1;
            r_prev_raw   <= i_raw_degree;
            r_prev_u     <= w_u;
            r_num        <= n_num;
            r_total      <= n_total;
            r_idx        <= n_idx;
            r_vld[r_idx] <= 1'b1;
        end
    end

    // prefetch the slot of the next transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring[r_idx] <= w_entry;
        end
        r_rd <= r_ring[n_idx];
    end

    assign o_push      = w_accept;
    assign o_numerator = n_num;

endmodule

// ----- rtl/auwa_queue.sv -----
module auwa_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [auwa_pkg::DATA_W-1:0] i_data,
    input  logic                        i_pop,
    output logic [auwa_pkg::DATA_W-1:0] o_data,
    output auwa_pkg::t_queue_status     o_status
);
    import auwa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_COUNT);
    assign o_status.empty = (r_count == '0);

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != FULL_COUNT)
        else $error("push while queue full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop while queue empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// ----- rtl/auwa_cdiv.sv -----
module auwa_cdiv #(
    parameter int DIVISOR = 4650
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic                             i_sign,
    input  logic [auwa_pkg::DATA_W-1:0]      i_a,
    output logic                             o_valid,
    output logic                             o_sign,
    output logic [auwa_pkg::DATA_W-1:0]      o_quot,
    output logic [$clog2(DIVISOR)-1:0]       o_rem
);
    import auwa_pkg::*;

    localparam int REM_W = $clog2(DIVISOR);
    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / DIVISOR;
    localparam logic [DATA_W-1:0] RECIP = RECIP_FULL[DATA_W-1:0];
    localparam logic [DATA_W-1:0] DIV   = DATA_W'(DIVISOR);

    logic              r_v1, r_v2;
    logic              r_s1, r_s2;
    logic [DATA_W-1:0] r_a1, r_a2;
    logic [63:0]       r_prod;
    logic [DATA_W-1:0] r_q0;
    logic [DATA_W-1:0] r_qd;

    logic [63:0]       w_prod;
    logic [DATA_W-1:0] w_est;
    logic [63:0]       w_qd;
    logic [DATA_W-1:0] w_rem;
    logic              w_fix;
    logic [DATA_W-1:0] w_rem_fixed;

    assign w_prod = {32'd0, i_a} * {32'd0, RECIP};
    assign w_est  = r_prod[63:32];
    assign w_qd   = {32'd0, w_est} * {32'd0, DIV};
    assign w_rem  = r_a2 - r_qd;
    assign w_fix  = (w_rem >= DIV);
    assign w_rem_fixed = w_fix ? w_rem - DIV : w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= i_sign;
            r_a1   <= i_a;
            r_prod <= w_prod;
            r_s2   <= r_s1;
            r_a2   <= r_a1;
            r_q0   <= w_est;
            r_qd   <= w_qd[DATA_W-1:0];
            o_sign <= r_s2;
            o_quot <= r_q0 + DATA_W'(w_fix);
            o_rem  <= w_rem_fixed[REM_W-1:0];
        end
    end

endmodule

// ----- rtl/auwa_back.sv -----
module auwa_back #(
    parameter int WINDOW_LENGTH = 30
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_queue_valid,
    input  logic [auwa_pkg::DATA_W-1:0]     i_queue_data,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [auwa_pkg::FILTERED_W-1:0] o_filtered_degree
);
    import auwa_pkg::*;

    localparam int WEIGHT_SUM = SCALE * WINDOW_LENGTH * (WINDOW_LENGTH + 1) / 2;
    localparam int WS_REM_W   = $clog2(WEIGHT_SUM);
    localparam int MOD_W      = $clog2(TURN_DEGREES);

    logic                  w_en;
    logic                  r_abs_valid;
    logic                  r_abs_sign;
    logic [DATA_W-1:0]     r_abs;

    logic                  w_v1, w_s1;
    logic [DATA_W-1:0]     w_q1;
    logic [WS_REM_W-1:0]   w_r1;
    logic                  w_v2, w_s2;
    logic [DATA_W-1:0]     w_q2;
    logic [MOD_W-1:0]      w_r2;
    logic [FILTERED_W-1:0] w_mag;

    // whole pipeline holds while the result register is stalled
    assign w_en  = !o_out_valid || !i_out_stall;
    assign o_pop = w_en && i_queue_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_valid <= 1'b0;
        end else if (w_en) begin
            r_abs_valid <= i_queue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_abs_sign <= i_queue_data[DATA_W-1];
            r_abs      <= i_queue_data[DATA_W-1] ? '0 - i_queue_data : i_queue_data;
        end
    end

    auwa_cdiv #(
        .DIVISOR (WEIGHT_SUM)
    ) u_div_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_abs_valid),
        .i_sign  (r_abs_sign),
        .i_a     (r_abs),
        .o_valid (w_v1),
        .o_sign  (w_s1),
        .o_quot  (w_q1),
        .o_rem   (w_r1)
    );

    auwa_cdiv #(
        .DIVISOR (TURN_DEGREES)
    ) u_div_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_sign  (w_s1),
        .i_a     (w_q1),
        .o_valid (w_v2),
        .o_sign  (w_s2),
        .o_quot  (w_q2),
        .o_rem   (w_r2)
    );

    assign w_mag = FILTERED_W'(w_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_filtered_degree <= w_s2 ? '0 - w_mag : w_mag;
        end
    end

`ifndef NO_ASSERTIONS
    a_turn_quot_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v2 |-> w_q2 <= DATA_W'(32'h7fff_ffff / (WEIGHT_SUM * TURN_DEGREES) + 1))
        else $error("turn quotient out of range");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v1 |-> DATA_W'(w_r1) < DATA_W'(WEIGHT_SUM))
        else $error("weight remainder out of range");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !o_pop)
        else $error("queue popped while result stalled");
`endif

endmodule

// ----- rtl/angle_unwrap_weighted_average_unit.sv -----
// Unwraps whole-degree direction samples into a continuous angle and returns a
// linear weighted moving average over the last WINDOW_LENGTH samples as a signed
// remainder of 360. One sample is accepted per cycle while the queue is not
// full; each result passes the unwrap and running-sum stage, a four-entry
// queue, a magnitude stage and two constant dividers of three stages each
// (reciprocal multiply, back multiply, correction) before the result register.
// The ring of scaled angles lives in a memory whose entries read as zero until
// first written, so no clearing pass follows reset. The user must write wrap
// thresholds through the configuration port while idle; this is not enforced.
module angle_unwrap_weighted_average_unit #(
    parameter int WINDOW_LENGTH = 30
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [auwa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [auwa_pkg::DEGREE_W-1:0]      i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [auwa_pkg::DEGREE_W-1:0]      i_raw_degree,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [auwa_pkg::FILTERED_W-1:0] o_filtered_degree
);
    import auwa_pkg::*;

    t_cfg              r_cfg;
    t_queue_status     w_status;
    logic              w_push;
    logic              w_pop;
    logic [DATA_W-1:0] w_num;
    logic [DATA_W-1:0] w_head;
    logic [FILTERED_W-1:0] w_filtered;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_low  <= WRAP_LOW_RESET;
            r_cfg.wrap_high <= WRAP_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WRAP_LOW: begin
                    r_cfg.wrap_low <= i_cfg_data;
                end
                CFG_WRAP_HIGH: begin
                    r_cfg.wrap_high <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    auwa_front #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_degree (i_raw_degree),
        .i_queue_full (w_status.full),
        .o_push       (w_push),
        .o_numerator  (w_num)
    );

    auwa_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_num),
        .i_pop    (w_pop),
        .o_data   (w_head),
        .o_status (w_status)
    );

    auwa_back #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_queue_valid     (!w_status.empty),
        .i_queue_data      (w_head),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_filtered_degree (w_filtered)
    );

    assign o_filtered_degree = signed'(w_filtered);

endmodule

// ----- tb/angle_unwrap_weighted_average_checker.sv -----
`timescale 1ns / 100ps

module angle_unwrap_weighted_average_checker #(
    parameter int WINDOW_LENGTH = 30
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [auwa_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [auwa_pkg::DEGREE_W-1:0]          i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic [auwa_pkg::DEGREE_W-1:0]          i_raw_degree,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic signed [auwa_pkg::FILTERED_W-1:0] i_filtered_degree,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    import auwa_pkg::*;

    localparam int WEIGHT_SUM = SCALE * WINDOW_LENGTH * (WINDOW_LENGTH + 1) / 2;

    logic [DEGREE_W-1:0]   wrap_low;
    logic [DEGREE_W-1:0]   wrap_high;
    logic [DATA_W-1:0]     angle_ring [WINDOW_LENGTH];
    int unsigned           ring_slot;
    logic [DATA_W-1:0]     ring_total;
    logic [DATA_W-1:0]     numerator;
    logic [DEGREE_W-1:0]   prev_raw;
    logic [DATA_W-1:0]     prev_unwrapped;
    logic                  seen_first;
    int                    fail_count = 0;

    logic signed [FILTERED_W-1:0] expected_degrees [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic signed [FILTERED_W-1:0] advance_average(
        input logic [DEGREE_W-1:0] raw
    );
        logic [DATA_W-1:0] unwrapped;
        logic [DATA_W-1:0] entry;
        int                quotient;
        int                remainder;
        if (!seen_first) begin
            unwrapped  = DATA_W'(raw) + DATA_W'(TURN_DEGREES);
            seen_first = 1'b1;
        end else begin
            unwrapped = prev_unwrapped + DATA_W'(raw) - DATA_W'(prev_raw);
            if (raw < wrap_low && prev_raw > wrap_high) begin
                unwrapped = unwrapped + DATA_W'(TURN_DEGREES);
            end else if (raw > wrap_high && prev_raw < wrap_low) begin
                unwrapped = unwrapped - DATA_W'(TURN_DEGREES);
            end
        end
        entry      = DATA_W'(SCALE) * unwrapped;
        numerator  = numerator + DATA_W'(WINDOW_LENGTH) * entry - ring_total;
        ring_total = ring_total - angle_ring[ring_slot] + entry;
        angle_ring[ring_slot] = entry;
        ring_slot  = (ring_slot == WINDOW_LENGTH - 1) ? 0 : ring_slot + 1;
        prev_raw       = raw;
        prev_unwrapped = unwrapped;
        quotient  = $signed(numerator) / WEIGHT_SUM;
        remainder = quotient % TURN_DEGREES;
        return remainder[FILTERED_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("checker: %s at %0t", what, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic signed [FILTERED_W-1:0] want;
        if (!i_rst_n) begin
            wrap_low       = WRAP_LOW_RESET;
            wrap_high      = WRAP_HIGH_RESET;
            foreach (angle_ring[k]) angle_ring[k] = '0;
            ring_slot      = 0;
            ring_total     = '0;
            numerator      = '0;
            prev_raw       = '0;
            prev_unwrapped = '0;
            seen_first     = 1'b0;
            expected_degrees.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WRAP_LOW) begin
                    wrap_low = i_cfg_data;
                end else if (i_cfg_index == CFG_WRAP_HIGH) begin
                    wrap_high = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_degrees.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no transaction pending",
                                              i_filtered_degree));
                end else begin
                    want = expected_degrees.pop_front();
                    if (i_filtered_degree !== want) begin
                        report_mismatch($sformatf("filtered_degree %0d, expected %0d",
                                                  i_filtered_degree, want));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_degrees.push_back(advance_average(i_raw_degree));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_degrees.size();
    end

endmodule

// ----- tb/tb_angle_unwrap_weighted_average_unit.sv -----
`timescale 1ns / 100ps

module tb_angle_unwrap_weighted_average_unit;

    import auwa_pkg::*;

    localparam int WINDOW_LENGTH  = 30;
    localparam int RESULT_LATENCY = 8;
    localparam int SETTLE_CYCLES  = 2 * RESULT_LATENCY;
    localparam int IDLE_MAX       = 18;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam int SPIN_ITEMS     = 330;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index = CFG_WRAP_LOW;
    logic [DEGREE_W-1:0]           cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [DEGREE_W-1:0]           raw_degree = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [FILTERED_W-1:0]  filtered_degree;
    int                            fail_count;
    int                            pending;
    bit                            quiet_send = 1'b0;
    bit                            quiet_take = 1'b0;

    logic [DEGREE_W-1:0] corner_samples [0:21] = '{
        9'd0, 9'd359, 9'd0, 9'd511, 9'd360, 9'd0, 9'd49, 9'd301, 9'd49, 9'd300,
        9'd49, 9'd50, 9'd301, 9'd50, 9'd255, 9'd256, 9'd170, 9'd85, 9'd1, 9'd511,
        9'd300, 9'd359
    };

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    angle_unwrap_weighted_average_unit #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_raw_degree      (raw_degree),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_filtered_degree (filtered_degree)
    );

    angle_unwrap_weighted_average_checker #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_raw_degree      (raw_degree),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_filtered_degree (filtered_degree),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    task automatic send_sample(input logic [DEGREE_W-1:0] raw);
        int unsigned gap;
        gap = quiet_send ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_degree <= raw;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [DEGREE_W-1:0] low,
                                  input logic [DEGREE_W-1:0] high);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WRAP_LOW;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= CFG_WRAP_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly a drifting heading that crosses north now and then, with noise
    task automatic run_heading_phase(input int count);
        int heading;
        int step;
        heading = $urandom_range(0, 359);
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
                step = int'($urandom_range(0, 40)) - 20;
                if ($urandom_range(0, 19) == 0) begin
                    step = $urandom_range(0, 359);
                end
                heading = (heading + 360 + step) % 360;
                send_sample(DEGREE_W'(heading));
            end else begin
                send_sample(DEGREE_W'($urandom_range(0, 511)));
            end
        end
    endtask

    // Every sample after the first wraps upward, so the unwrapped angle climbs steadily
    task automatic run_spin(input int count);
        repeat (count) send_sample(DEGREE_W'($urandom_range(1, 510)));
    endtask

    initial begin : result_sink
        int unsigned gap;
        forever begin
            gap = quiet_take ? 0 : $urandom_range(0, IDLE_MAX);
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial begin : stimulus
        logic [DEGREE_W-1:0] low;
        logic [DEGREE_W-1:0] high;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (corner_samples[k]) send_sample(corner_samples[k]);
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin low = 9'd0;   high = 9'd0;   end
                1: begin low = 9'd511; high = 9'd511; end
                2: begin low = 9'd0;   high = 9'd511; end
                3: begin low = 9'd359; high = 9'd0;   end
                4: begin low = 9'd1;   high = 9'd358; end
                5: begin low = 9'd50;  high = 9'd300; end
                default: begin
                    low  = DEGREE_W'($urandom_range(0, 511));
                    high = DEGREE_W'($urandom_range(0, 511));
                end
            endcase
            wait_drained();
            set_thresholds(low, high);
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_take = ($urandom_range(0, 3) == 0);
            run_heading_phase(PHASE_ITEMS);
            if (phase == 4) begin
                wait_drained();
                set_thresholds(9'd511, 9'd0);
                quiet_send = 1'b1;
                quiet_take = 1'b1;
                run_spin(SPIN_ITEMS);
            end
        end
        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
